### hw/rtl/fully_associative_lru_cache_lookup_unit_assert.svh
// Assertion macros for the fully associative LRU lookup unit.
// Used by the top level only; needs a signal named clock and one named reset in scope.
`ifndef FULLY_ASSOCIATIVE_LRU_CACHE_LOOKUP_UNIT_ASSERT_SVH
`define FULLY_ASSOCIATIVE_LRU_CACHE_LOOKUP_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define FALRU_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("falru assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define FALRU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("falru assertion failed");

`endif

### hw/rtl/falru_pkg.sv
// Shared constants and types for the fully associative LRU lookup unit.
// No dependencies; the files that use it refer to it by scoped names.
package falru_pkg;

   localparam int ADDR_BITS           = 64;
   localparam int COUNT_BITS          = 32;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = 32'hffff_ffff;

   localparam int LINES_DEFAULT       = 512;
   localparam int OFFSET_BITS_DEFAULT = 6;
   localparam int TAG_BITS_DEFAULT    = 32;

   typedef enum logic {
      FALRU_IDLE,
      FALRU_BUSY
   } falru_state_type;

endpackage

### hw/rtl/falru_req_if.sv
// Request channel carrying one access address per item.
// Depends on falru_pkg for the address width.
interface falru_req_if;
   logic                           valid;
   logic                           ready;
   logic [falru_pkg::ADDR_BITS-1:0] address;

   modport source (output valid, output address, input ready);
   modport sink   (input valid, input address, output ready);
endinterface

### hw/rtl/falru_rsp_if.sv
// Response channel carrying the hit flag and running counts per item.
// Depends on falru_pkg for the counter width.
interface falru_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            hit;
   logic [falru_pkg::COUNT_BITS-1:0] hit_count;
   logic [falru_pkg::COUNT_BITS-1:0] miss_count;

   modport source (output valid, output hit, output hit_count, output miss_count,
                   input ready);
   modport sink   (input valid, input hit, input hit_count, input miss_count,
                   output ready);
endinterface

### hw/rtl/falru_cell.sv
// One tag cell of the recency chain: holds a tag, compares it with the key
// and takes its lower neighbor's tag when the chain shifts. No package use.
module falru_cell #(
   parameter int TAG_BITS  = 32,
   parameter int FILL_BITS = 10,
   parameter int INDEX     = 0
) (
   input  logic                 clock,
   input  logic                 load,
   input  logic                 shift,
   input  logic [TAG_BITS-1:0]  key,
   input  logic [TAG_BITS-1:0]  prev_tag,
   input  logic [FILL_BITS-1:0] fill,
   output logic [TAG_BITS-1:0]  tag,
   output logic                 match
);

   logic [TAG_BITS-1:0] tag_ff;
   logic [TAG_BITS-1:0] tag_in;
   logic                valid;

   // A cell holds a live tag only while it sits below the fill count.
   assign valid = (fill > FILL_BITS'(INDEX));
   assign match = valid && (tag_ff == key);
   assign tag   = tag_ff;

   assign tag_in = (load && shift) ? prev_tag : tag_ff;

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
   end

endmodule

### hw/rtl/falru_scan.sv
// Parallel prefix OR over the match row: seen[i] is set when any cell at or
// below position i matched. No package use.
module falru_scan #(
   parameter int N = 512
) (
   input  logic [N-1:0] match,
   output logic [N-1:0] seen
);

   localparam int LEVELS = $clog2(N);

   logic [N-1:0] level [0:LEVELS];

   assign level[0] = match;

   for (genvar k = 0; k < LEVELS; k++) begin : g_level
      for (genvar i = 0; i < N; i++) begin : g_bit
         if (i >= (1 << k)) begin : g_merge
            assign level[k+1][i] = level[k][i] | level[k][i-(1<<k)];
         end else begin : g_pass
            assign level[k+1][i] = level[k][i];
         end
      end
   end

   assign seen = level[LEVELS];

endmodule

### hw/rtl/fully_associative_lru_cache_lookup_unit.sv
// Fully associative LRU tag lookup built as a row of tag cells, most recent at cell 0.
// The address is registered as the key; the compare-and-shift pass over the row then runs in the
// busy state, waiting while the previous result still sits in the output register, and its result
// is registered there. A new address is accepted only in the idle state, after the pass for the
// previous one. Reset clears the fill count, both counters and the handshake state; tags are not
// cleared, since cells at or above the fill count are never compared.
module fully_associative_lru_cache_lookup_unit #(
   parameter int LINES       = falru_pkg::LINES_DEFAULT,
   parameter int OFFSET_BITS = falru_pkg::OFFSET_BITS_DEFAULT,
   parameter int TAG_BITS    = falru_pkg::TAG_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   falru_req_if.sink   req_if,
   falru_rsp_if.source rsp_if
);

   localparam int FILL_BITS = $clog2(LINES + 1);
   localparam int CB        = falru_pkg::COUNT_BITS;

   falru_pkg::falru_state_type state_ff, state_in;

   logic [TAG_BITS-1:0]  tag_ff, tag_in;
   logic [FILL_BITS-1:0] fill_ff, fill_in;
   logic [CB-1:0]        hits_ff, hits_in;
   logic [CB-1:0]        miss_ff, miss_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_hit_ff, rsp_hit_in;

   logic [falru_pkg::ADDR_BITS-1:0] line_addr;
   logic                 req_take;
   logic                 update;
   logic                 hit;
   logic [LINES-1:0]     match;
   logic [LINES-1:0]     seen;
   logic [TAG_BITS-1:0]  cell_tag [0:LINES-1];

   assign req_take  = req_if.valid && req_if.ready;
   assign line_addr = req_if.address >> OFFSET_BITS;
   assign tag_in    = req_take ? TAG_BITS'(line_addr) : tag_ff;

   // The update pass waits while an earlier result still sits in the output register.
   assign update = (state_ff == falru_pkg::FALRU_BUSY) && (!rsp_valid_ff || rsp_if.ready);
   assign hit    = seen[LINES-1];

   for (genvar i = 0; i < LINES; i++) begin : g_cell
      logic                shift;
      logic [TAG_BITS-1:0] prev_tag;

      if (i == 0) begin : g_head
         assign shift    = 1'b1;
         assign prev_tag = tag_ff;
      end else begin : g_body
         // Cells up to and including the matching one move up; on a miss all do.
         assign shift    = !seen[i-1];
         assign prev_tag = cell_tag[i-1];
      end

      falru_cell #(
         .TAG_BITS  (TAG_BITS),
         .FILL_BITS (FILL_BITS),
         .INDEX     (i)
      ) u_cell (
         .clock    (clock),
         .load     (update),
         .shift    (shift),
         .key      (tag_ff),
         .prev_tag (prev_tag),
         .fill     (fill_ff),
         .tag      (cell_tag[i]),
         .match    (match[i])
      );
   end

   falru_scan #(
      .N (LINES)
   ) u_scan (
      .match (match),
      .seen  (seen)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         falru_pkg::FALRU_IDLE: begin
            if (req_take) begin
               state_in = falru_pkg::FALRU_BUSY;
            end
         end
         falru_pkg::FALRU_BUSY: begin
            if (update) begin
               state_in = falru_pkg::FALRU_IDLE;
            end
         end
         default: begin
            state_in = falru_pkg::FALRU_IDLE;
         end
      endcase
   end

   always_comb begin
      fill_in      = fill_ff;
      hits_in      = hits_ff;
      miss_in      = miss_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      if (update) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = hit;
         if (hit) begin
            if (hits_ff != falru_pkg::COUNT_MAX) begin
               hits_in = hits_ff + 1'b1;
            end
         end else begin
            if (miss_ff != falru_pkg::COUNT_MAX) begin
               miss_in = miss_ff + 1'b1;
            end
            if (fill_ff < FILL_BITS'(LINES)) begin
               fill_in = fill_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= falru_pkg::FALRU_IDLE;
         fill_ff      <= '0;
         hits_ff      <= '0;
         miss_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         hits_ff      <= hits_in;
         miss_ff      <= miss_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff     <= tag_in;
      rsp_hit_ff <= rsp_hit_in;
   end

   // The counters change only on an update, which waits for a free output slot,
   // so they can drive the response directly.
   assign req_if.ready      = (state_ff == falru_pkg::FALRU_IDLE);
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.hit        = rsp_hit_ff;
   assign rsp_if.hit_count  = hits_ff;
   assign rsp_if.miss_count = miss_ff;

`include "fully_associative_lru_cache_lookup_unit_assert.svh"

   // Tags enter only on a miss, so no two live cells may match the same key.
   `FALRU_ASSERT_NOW(a_unique_match, state_ff == falru_pkg::FALRU_BUSY, $onehot0(match))
   `FALRU_ASSERT_NOW(a_fill_bound, 1'b1, fill_ff <= FILL_BITS'(LINES))
   `FALRU_ASSERT_NEXT(a_hit_keeps_fill, update && hit, fill_ff == $past(fill_ff))
   `FALRU_ASSERT_NEXT(a_miss_counts, update && !hit && miss_ff != falru_pkg::COUNT_MAX,
      miss_ff == $past(miss_ff) + 1'b1)

endmodule

### dv/fully_associative_lru_cache_lookup_unit_checker.sv
// Checker for the fully associative LRU lookup unit: keeps its own recency list and counters,
// predicts one result per accepted address and compares it with the response channel.
// Depends on falru_pkg, falru_req_if and falru_rsp_if.
module fully_associative_lru_cache_lookup_unit_checker #(
   parameter int LINES       = falru_pkg::LINES_DEFAULT,
   parameter int OFFSET_BITS = falru_pkg::OFFSET_BITS_DEFAULT,
   parameter int TAG_BITS    = falru_pkg::TAG_BITS_DEFAULT
) (
   input  logic  clock,
   input  logic  reset,
   falru_req_if  req,
   falru_rsp_if  rsp,
   output int    errors,
   output int    outstanding
);

   typedef struct packed {
      logic                             hit;
      logic [falru_pkg::COUNT_BITS-1:0] hits;
      logic [falru_pkg::COUNT_BITS-1:0] misses;
   } lookup_result_type;

   // Index 0 holds the least recently used tag, index lines_used-1 the most recent.
   logic [TAG_BITS-1:0]              recent_tags [LINES];
   int                               lines_used;
   logic [falru_pkg::COUNT_BITS-1:0] hits_total;
   logic [falru_pkg::COUNT_BITS-1:0] misses_total;
   lookup_result_type                expected_lookups [$];
   lookup_result_type                oldest;

   task automatic lookup_line(input logic [falru_pkg::ADDR_BITS-1:0] address);
      logic [TAG_BITS-1:0] tag;
      int                  slot;
      lookup_result_type   outcome;
      tag = address[OFFSET_BITS +: TAG_BITS];
      slot = -1;
      for (int i = 0; i < lines_used; i++) begin
         if (slot < 0 && recent_tags[i] == tag) slot = i;
      end
      if (slot >= 0) begin
         if (hits_total != falru_pkg::COUNT_MAX) hits_total++;
         for (int i = slot + 1; i < lines_used; i++) recent_tags[i-1] = recent_tags[i];
         recent_tags[lines_used-1] = tag;
      end else begin
         if (misses_total != falru_pkg::COUNT_MAX) misses_total++;
         if (lines_used < LINES) begin
            recent_tags[lines_used] = tag;
            lines_used++;
         end else begin
            // Full store: the least recent tag falls out at the bottom.
            for (int i = 1; i < LINES; i++) recent_tags[i-1] = recent_tags[i];
            recent_tags[LINES-1] = tag;
         end
      end
      outcome.hit    = (slot >= 0);
      outcome.hits   = hits_total;
      outcome.misses = misses_total;
      expected_lookups.push_back(outcome);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         lines_used   = 0;
         hits_total   = '0;
         misses_total = '0;
         errors       = 0;
         expected_lookups.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_lookups.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual hit %0b hits %0d misses %0d",
                        $time, rsp.hit, rsp.hit_count, rsp.miss_count);
               errors++;
            end else begin
               oldest = expected_lookups.pop_front();
               if (rsp.hit !== oldest.hit) begin
                  $display("%0t: hit mismatch, expected %0b, actual %0b",
                           $time, oldest.hit, rsp.hit);
                  errors++;
               end
               if (rsp.hit_count !== oldest.hits) begin
                  $display("%0t: hit_count mismatch, expected %0d, actual %0d",
                           $time, oldest.hits, rsp.hit_count);
                  errors++;
               end
               if (rsp.miss_count !== oldest.misses) begin
                  $display("%0t: miss_count mismatch, expected %0d, actual %0d",
                           $time, oldest.misses, rsp.miss_count);
                  errors++;
               end
            end
         end
         if (req.valid && req.ready) lookup_line(req.address);
      end
      outstanding = expected_lookups.size();
   end

endmodule

### dv/fully_associative_lru_cache_lookup_unit_tb.sv
// Testbench top for the fully associative LRU lookup unit: clock, reset, address stimulus
// with random idling on both channels, and the final verdict from the checker's error count.
// Depends on falru_pkg, falru_req_if, falru_rsp_if, the lookup unit and its checker.
module fully_associative_lru_cache_lookup_unit_tb;

   localparam int OFFSET_W = falru_pkg::OFFSET_BITS_DEFAULT;
   localparam int TAG_W    = falru_pkg::TAG_BITS_DEFAULT;
   localparam int UPPER_W  = falru_pkg::ADDR_BITS - OFFSET_W - TAG_W;

   logic             clock;
   logic             reset;
   logic             calm;
   int               errors;
   int               outstanding;
   logic [TAG_W-1:0] tag_base;
   int unsigned      fresh_tags;

   falru_req_if req_chan ();
   falru_rsp_if rsp_chan ();

   fully_associative_lru_cache_lookup_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_chan),
      .rsp_if (rsp_chan)
   );

   fully_associative_lru_cache_lookup_unit_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .rsp         (rsp_chan),
      .errors      (errors),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("simulation failed");
      $finish;
   end

   // The receiver stalls in random bursts unless the run is in a calm stretch.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
      end
   end

   // Called and left at a falling edge; valid stays high from one item to the next unless a random idle drops it.
   task automatic send_address(input logic [falru_pkg::ADDR_BITS-1:0] address);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.address <= address;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   // Random bits above the tag and in the line offset must not change the lookup.
   task automatic send_tag(input logic [TAG_W-1:0] tag);
      logic [UPPER_W-1:0]  upper;
      logic [OFFSET_W-1:0] offset;
      upper  = UPPER_W'($urandom);
      offset = OFFSET_W'($urandom);
      send_address({upper, tag, offset});
   endtask

   // Mixes fresh tags, reuse of one of the last reach fresh tags, and fully random tags.
   task automatic run_accesses(input int count, input int fresh_pct, input int noise_pct,
                               input int reach);
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < noise_pct) begin
            send_tag(TAG_W'($urandom));
         end else if (pick < noise_pct + fresh_pct || fresh_tags == 0) begin
            send_tag(tag_base + fresh_tags);
            fresh_tags++;
         end else begin
            send_tag(tag_base + fresh_tags - $urandom_range(1, reach));
         end
      end
   endtask

   initial begin
      logic [falru_pkg::ADDR_BITS-1:0] directed [$];
      reset            = 1'b1;
      calm             = 1'b0;
      req_chan.valid   = 1'b0;
      req_chan.address = '0;
      tag_base         = TAG_W'($urandom);
      fresh_tags       = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Field extremes, aliasing through the bits above the tag, and moves from the
      // middle, the most recent and the least recent end of the list.
      directed = '{64'h0000_0000_0000_0000, 64'h0000_0000_0000_003f,
                   64'hffff_ffff_ffff_ffff, 64'hffff_ffc0_0000_0000,
                   64'h0000_003f_ffff_ffc0, 64'h0000_0000_0000_0040,
                   64'h0000_0000_0000_0080, 64'h0000_0000_0000_00c0,
                   64'h0000_0000_0000_0040, 64'h0000_0000_0000_00c0,
                   64'h0000_0000_0000_0000, 64'h0000_0020_0000_0000,
                   64'h0000_0000_0000_1000, 64'h2000_0000_0000_0020,
                   64'h0000_0000_0000_1000, 64'h0000_0000_0000_0080};
      foreach (directed[i]) send_address(directed[i]);

      // Fill the store past its capacity with mostly new tags.
      run_accesses(700, 75, 0, 600);

      // Let every pending result drain before going on.
      req_chan.valid <= 1'b0;
      wait (outstanding == 0);
      @(negedge clock);

      // Reuse distances around the store depth exercise the eviction boundary.
      run_accesses(500, 12, 5, 640);
      calm = 1'b1;
      run_accesses(150, 10, 10, 520);
      calm = 1'b0;
      run_accesses(450, 10, 40, 300);
      calm = 1'b1;
      run_accesses(200, 12, 5, 600);

      req_chan.valid <= 1'b0;
      wait (outstanding == 0);
      repeat (16) @(posedge clock);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/falru_pkg.sv
hw/rtl/falru_req_if.sv
hw/rtl/falru_rsp_if.sv
hw/rtl/falru_cell.sv
hw/rtl/falru_scan.sv
hw/rtl/fully_associative_lru_cache_lookup_unit.sv
dv/fully_associative_lru_cache_lookup_unit_checker.sv
dv/fully_associative_lru_cache_lookup_unit_tb.sv
